>>> rtl/websocket_frame_deframer_unmask_top_defines.svh
// assertion macros for the deframer checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define WSDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed: %m");

// next-cycle implication, sampled on clk, off during rst
`define WSDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed: %m");

`endif

>>> rtl/wsdf_pkg.sv
`default_nettype none

package wsdf_pkg;

  localparam int ByteW   = 8;
  localparam int KindW   = 2;
  localparam int OpcodeW = 4;
  localparam int LenW    = 64;
  localparam int KeyW    = 32;

  // packed widths on the stream ports
  localparam int OutDataBits = ByteW + 1 + OpcodeW + LenW;
  localparam int OutDataW    = ((OutDataBits + 7) / 8) * 8;

  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_HEADER  = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR   = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   payload_byte;
    logic               fin;
    logic [OpcodeW-1:0] opcode;
    logic [LenW-1:0]    payload_length;
    logic               last;
  } wsdf_result_t;

  typedef struct packed {
    logic             step;
    logic [ByteW-1:0] in_byte;
  } wsdf_item_t;

endpackage

`default_nettype wire

>>> rtl/wsdf_in_reg.sv
`default_nettype none

module wsdf_in_reg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [wsdf_pkg::ByteW-1:0] s_tdata,
  input  wire logic                     advance,
  output logic                          held,
  output wsdf_pkg::wsdf_item_t          item
);

  logic                     valid;
  logic [wsdf_pkg::ByteW-1:0] data;

  // a held byte that moves on frees the slot in the same cycle
  assign s_tready = !valid || advance;
  assign held     = valid;
  assign item.step    = valid && advance;
  assign item.in_byte = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      data <= s_tdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsdf_parser.sv
`default_nettype none

module wsdf_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wsdf_pkg::wsdf_item_t item,
  output logic                      res_valid,
  output wsdf_pkg::wsdf_result_t    res
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_ERROR   = 3'd5;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  logic [2:0]                      phase, phase_next;
  logic [2:0]                      ext_byte_count, ext_byte_count_next;
  logic                            frame_fin, frame_fin_next;
  logic [wsdf_pkg::OpcodeW-1:0]    frame_opcode, frame_opcode_next;
  logic [wsdf_pkg::LenW-1:0]       frame_length, frame_length_next;
  logic [wsdf_pkg::LenW-1:0]       bytes_remaining, bytes_remaining_next;
  logic [wsdf_pkg::KeyW-1:0]       mask_key, mask_key_next;
  logic [1:0]                      key_index, key_index_next;

  logic [wsdf_pkg::ByteW-1:0] b;
  logic [6:0]                 len7;
  logic [wsdf_pkg::ByteW-1:0] key_byte;
  logic                       len_zero;
  logic                       rem_one;

  assign b        = item.in_byte;
  assign len7     = b[6:0];
  assign len_zero = (frame_length == '0);
  assign rem_one  = (bytes_remaining == wsdf_pkg::LenW'(1));

  // key bytes were shifted in first byte high
  always_comb begin
    unique case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    ext_byte_count_next  = ext_byte_count;
    frame_fin_next       = frame_fin;
    frame_opcode_next    = frame_opcode;
    frame_length_next    = frame_length;
    bytes_remaining_next = bytes_remaining;
    mask_key_next        = mask_key;
    key_index_next       = key_index;
    res_valid            = 1'b0;
    res.kind           = wsdf_pkg::KIND_PAYLOAD;
    res.payload_byte   = '0;
    res.fin            = frame_fin;
    res.opcode         = frame_opcode;
    res.payload_length = frame_length;
    res.last           = 1'b0;

    unique case (phase)
      PH_HDR1: begin
        if (!b[7]) begin
          phase_next         = PH_ERROR;
          res_valid          = item.step;
          res.kind           = wsdf_pkg::KIND_ERROR;
          res.payload_length = '0;
        end else begin
          mask_key_next  = '0;
          key_index_next = 2'd0;
          if (len7 == LEN_EXT16) begin
            frame_length_next   = '0;
            ext_byte_count_next = 3'd1;
            phase_next          = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            frame_length_next   = '0;
            ext_byte_count_next = 3'd7;
            phase_next          = PH_EXT;
          end else begin
            frame_length_next = {{(wsdf_pkg::LenW-7){1'b0}}, len7};
            phase_next        = PH_KEY;
          end
        end
      end
      PH_EXT: begin
        frame_length_next = {frame_length[wsdf_pkg::LenW-9:0], b};
        if (ext_byte_count == 3'd0) begin
          phase_next = PH_KEY;
        end else begin
          ext_byte_count_next = ext_byte_count - 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[wsdf_pkg::KeyW-9:0], b};
        if (key_index != 2'd3) begin
          key_index_next = key_index + 2'd1;
        end else begin
          key_index_next       = 2'd0;
          bytes_remaining_next = frame_length;
          phase_next           = len_zero ? PH_HDR0 : PH_PAYLOAD;
          res_valid            = item.step;
          res.kind             = wsdf_pkg::KIND_HEADER;
          res.last             = len_zero;
        end
      end
      PH_PAYLOAD: begin
        key_index_next       = key_index + 2'd1;
        bytes_remaining_next = bytes_remaining - wsdf_pkg::LenW'(1);
        if (rem_one) begin
          phase_next = PH_HDR0;
        end
        res_valid        = item.step;
        res.payload_byte = b ^ key_byte;
        res.last         = rem_one;
      end
      PH_ERROR: begin
        // sticky until reset
      end
      default: begin
        frame_fin_next      = b[7];
        frame_opcode_next   = b[3:0];
        ext_byte_count_next = 3'd0;
        phase_next          = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      ext_byte_count  <= '0;
      frame_fin       <= 1'b0;
      frame_opcode    <= '0;
      frame_length    <= '0;
      bytes_remaining <= '0;
      mask_key        <= '0;
      key_index       <= '0;
    end else if (item.step) begin
      phase           <= phase_next;
      ext_byte_count  <= ext_byte_count_next;
      frame_fin       <= frame_fin_next;
      frame_opcode    <= frame_opcode_next;
      frame_length    <= frame_length_next;
      bytes_remaining <= bytes_remaining_next;
      mask_key        <= mask_key_next;
      key_index       <= key_index_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsdf_out_reg.sv
`default_nettype none

module wsdf_out_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          res_valid,
  input  wire wsdf_pkg::wsdf_result_t        res,
  output logic                               slot_free,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [wsdf_pkg::OutDataW-1:0]      m_tdata,
  output logic [wsdf_pkg::KindW-1:0]         m_tuser,
  output logic                               m_tlast
);

  logic                   valid;
  wsdf_pkg::wsdf_result_t held;

  assign slot_free = !valid || m_tready;
  assign m_tvalid  = valid;
  assign m_tuser   = held.kind;
  assign m_tlast   = held.last;
  assign m_tdata   = wsdf_pkg::OutDataW'({held.payload_length, held.opcode, held.fin,
                                          held.payload_byte});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (slot_free) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/websocket_frame_deframer_unmask_top.sv
// channel  dir  tdata (low bit up)                              tuser  tlast
// s_*      in   [7:0] in_byte                                   -      -
// m_*      out  [7:0] payload_byte, [8] fin, [12:9] opcode,     kind   last
//               [76:13] payload_length, [79:77] zero
// one byte per cycle sustained while m_* is not stalled; each result is registered at m_*
// the path is input register, one parse step on the frame state, output register
// rst is synchronous and returns the parser to the first header byte
// s_tready drops only while a held byte waits for a stalled m_* slot
// an unmasked frame gives one error request, then input bytes are dropped until rst
`default_nettype none

module websocket_frame_deframer_unmask_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [wsdf_pkg::ByteW-1:0]    s_tdata,   // [7:0] in_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [wsdf_pkg::OutDataW-1:0]      m_tdata,   // payload_byte, fin, opcode, length
  output logic [wsdf_pkg::KindW-1:0]         m_tuser,   // [1:0] kind
  output logic                               m_tlast
);

  wsdf_pkg::wsdf_item_t   item;
  wsdf_pkg::wsdf_result_t res;
  logic                   res_valid;
  logic                   slot_free;
  logic                   held;

  wsdf_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (slot_free),
    .held     (held),
    .item     (item)
  );

  wsdf_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wsdf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid && held),
    .res       (res),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/wsdf_checker.sv
`default_nettype none
`include "websocket_frame_deframer_unmask_top_defines.svh"

module wsdf_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [wsdf_pkg::OutDataW-1:0] m_tdata,
  input wire logic [wsdf_pkg::KindW-1:0]  m_tuser,
  input wire logic                        m_tlast
);

  `WSDF_ASSERT_NOW(a_kind_known, m_tvalid, m_tuser <= wsdf_pkg::KIND_ERROR)

  `WSDF_ASSERT_NOW(a_byte_zero, m_tvalid && m_tuser != wsdf_pkg::KIND_PAYLOAD, m_tdata[7:0] == 8'd0)

  `WSDF_ASSERT_NOW(a_error_form, m_tvalid && m_tuser == wsdf_pkg::KIND_ERROR, !m_tlast && m_tdata[76:13] == 64'd0)

  // nothing follows an error request
  `WSDF_ASSERT_NEXT(a_error_final, m_tvalid && m_tready && m_tuser == wsdf_pkg::KIND_ERROR, !m_tvalid)

  `WSDF_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind websocket_frame_deframer_unmask_top wsdf_checker u_wsdf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
